FILE: sv/tse_pkg.sv
// ----------------------------------------------------------------------------
// tse_pkg
// shared widths, character codes and types for the text statistics engine
// ----------------------------------------------------------------------------
package tse_pkg;

  localparam int CHAR_W = 8;
  localparam int CNT_W  = 16;
  localparam int BINS   = 1 << CHAR_W;

  localparam logic [CNT_W-1:0]  MAX_CHARS = 16'd65535;
  localparam logic [CNT_W-1:0]  CNT_SAT   = 16'hFFFF;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;

  typedef struct packed {
    logic              en;
    logic [CHAR_W-1:0] addr;
    logic [CNT_W-1:0]  data;
  } hist_wr_t;

  typedef struct packed {
    logic              en;
    logic [CHAR_W-1:0] addr;
  } hist_rd_t;

  function automatic logic is_sep(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_LF) || (c == CH_NUL) || (c == CH_COMMA);
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_SAT) ? CNT_SAT : v + CNT_W'(1);
  endfunction

endpackage

FILE: sv/tse_hist.sv
// ----------------------------------------------------------------------------
// tse_hist
// 256-bin byte histogram in a synchronous ram with per-bin valid bits,
// a registered read and forwarding of a same-cycle write
// ----------------------------------------------------------------------------
module tse_hist
  import tse_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  hist_rd_t         rd,
  input  hist_wr_t         wr,
  input  logic             clr,
  output logic [CNT_W-1:0] cur_count
);

  logic [CNT_W-1:0] mem [BINS];
  logic [CNT_W-1:0] rdata_r;
  logic [BINS-1:0]  vld_r;
  logic [BINS-1:0]  vld_nxt;
  logic             hv_r;
  logic             fwd_r;
  logic [CNT_W-1:0] fwd_val_r;
  logic             zero_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rdata_r   <= mem[rd.addr];
      hv_r      <= vld_r[rd.addr];
      fwd_val_r <= wr.data;
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (clr) begin
      vld_nxt = '0;
    end else if (wr.en) begin
      vld_nxt[wr.addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      fwd_r  <= 1'b0;
      zero_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      if (rd.en) begin
        fwd_r  <= wr.en && (wr.addr == rd.addr);
        zero_r <= clr;
      end
    end
  end

  always_comb begin
    if (zero_r) begin
      cur_count = '0;
    end else if (fwd_r) begin
      cur_count = fwd_val_r;
    end else if (hv_r) begin
      cur_count = rdata_r;
    end else begin
      cur_count = '0;
    end
  end

  a_clr_no_wr: assert property (@(posedge clk) disable iff (!rst_n)
    clr |-> !wr.en)
    else $error("histogram clear and write in the same cycle");

  a_clr_empties: assert property (@(posedge clk) disable iff (!rst_n)
    clr |=> vld_r == '0)
    else $error("valid bits not cleared");

  a_wr_marks: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en && !clr |=> vld_r[$past(wr.addr)])
    else $error("written bin not marked valid");

endmodule

FILE: sv/text_statistics_engine.sv
// ----------------------------------------------------------------------------
// text_statistics_engine
// streaming word, line and byte-frequency statistics over a text stream
// ----------------------------------------------------------------------------
// Takes one text byte per cycle (in_tuser low) while in_tready is high, or
// an end marker (in_tuser high). The histogram bin of a byte is read from
// the ram in the accept cycle and updated the next cycle, with a write to
// the same bin forwarded to a back-to-back read. The end marker returns
// one statistics result on the out channel; it waits in the update stage
// while an earlier result is still pending on the output register,
// holding in_tready low. After the end marker all statistics restart
// from empty. Bytes past the first 65535 of a text are ignored; counts
// saturate at 65535.
// ----------------------------------------------------------------------------
module text_statistics_engine
  import tse_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // char_in
  input  logic         in_tuser,   // text_end
  output logic         out_tvalid,
  input  logic         out_tready,
  // word_count, line_count, longest_line_number, longest_line_length,
  // top_char, top_char_count, longest_word_offset, longest_word_length
  output logic [119:0] out_tdata
);

  logic in_acc;

  logic              s1_vld_r;
  logic              s1_end_r;
  logic [CHAR_W-1:0] s1_char_r;

  logic [CHAR_W-1:0] prev_r, prev_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic [CNT_W-1:0]  words_r, words_nxt;
  logic [CNT_W-1:0]  lines_r, lines_nxt;
  logic [CNT_W-1:0]  ln_begin_r, ln_begin_nxt;
  logic [CNT_W-1:0]  best_line_len_r, best_line_len_nxt;
  logic [CNT_W-1:0]  best_line_num_r, best_line_num_nxt;
  logic [CNT_W-1:0]  wd_begin_r, wd_begin_nxt;
  logic [CNT_W-1:0]  best_word_len_r, best_word_len_nxt;
  logic [CNT_W-1:0]  best_wd_begin_r, best_wd_begin_nxt;
  logic [CHAR_W-1:0] top_code_r, top_code_nxt;
  logic [CNT_W-1:0]  top_total_r, top_total_nxt;

  logic         out_tvalid_r;
  logic [119:0] out_tdata_r;

  logic             byte_fire;
  logic             end_fire;
  logic             active;
  logic             sep;
  logic             prev_sep;
  logic [CNT_W-1:0] cur_count;
  logic [CNT_W-1:0] new_count;
  logic [CNT_W-1:0] word_len;
  logic [CNT_W-1:0] line_len;

  hist_rd_t hrd;
  hist_wr_t hwr;

  assign in_tready = !(s1_vld_r && s1_end_r && out_tvalid_r);
  assign in_acc    = in_tvalid && in_tready;
  assign byte_fire = s1_vld_r && !s1_end_r;
  assign end_fire  = s1_vld_r && s1_end_r && !out_tvalid_r;
  assign active    = byte_fire && (pos_r < MAX_CHARS);

  assign sep       = is_sep(s1_char_r);
  assign prev_sep  = is_sep(prev_r);
  assign new_count = sat_inc(cur_count);
  assign word_len  = pos_r - wd_begin_r;

  assign hrd.en   = in_acc && !in_tuser;
  assign hrd.addr = in_tdata;
  assign hwr.en   = active;
  assign hwr.addr = s1_char_r;
  assign hwr.data = new_count;

  tse_hist u_hist (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd        (hrd),
    .wr        (hwr),
    .clr       (end_fire),
    .cur_count (cur_count)
  );

  always_comb begin
    prev_nxt          = prev_r;
    pos_nxt           = pos_r;
    words_nxt         = words_r;
    lines_nxt         = lines_r;
    ln_begin_nxt      = ln_begin_r;
    best_line_len_nxt = best_line_len_r;
    best_line_num_nxt = best_line_num_r;
    wd_begin_nxt      = wd_begin_r;
    best_word_len_nxt = best_word_len_r;
    best_wd_begin_nxt = best_wd_begin_r;
    top_code_nxt      = top_code_r;
    top_total_nxt     = top_total_r;

    if (prev_r == CH_LF) begin
      line_len = 16'd1;
    end else begin
      line_len = pos_r - ln_begin_r + CNT_W'(1);
    end

    if (end_fire) begin
      prev_nxt          = CH_LF;
      pos_nxt           = '0;
      words_nxt         = '0;
      lines_nxt         = '0;
      ln_begin_nxt      = '0;
      best_line_len_nxt = '0;
      best_line_num_nxt = 16'd1;
      wd_begin_nxt      = '0;
      best_word_len_nxt = '0;
      best_wd_begin_nxt = '0;
      top_code_nxt      = '0;
      top_total_nxt     = '0;
    end else if (active) begin
      if ((new_count > top_total_r) ||
          ((new_count == top_total_r) && (s1_char_r < top_code_r))) begin
        top_total_nxt = new_count;
        top_code_nxt  = s1_char_r;
      end

      if (prev_sep && !sep) begin
        words_nxt    = sat_inc(words_r);
        wd_begin_nxt = pos_r;
      end else if (sep && !prev_sep) begin
        if (word_len > best_word_len_r) begin
          best_word_len_nxt = word_len;
          best_wd_begin_nxt = wd_begin_r;
        end
      end

      if (prev_r == CH_LF) begin
        lines_nxt    = sat_inc(lines_r);
        ln_begin_nxt = pos_r;
      end
      if ((s1_char_r == CH_LF) && (line_len > best_line_len_r)) begin
        best_line_len_nxt = line_len;
        best_line_num_nxt = lines_nxt;
      end

      prev_nxt = s1_char_r;
      pos_nxt  = pos_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r        <= 1'b0;
      s1_end_r        <= 1'b0;
      prev_r          <= CH_LF;
      pos_r           <= '0;
      words_r         <= '0;
      lines_r         <= '0;
      ln_begin_r      <= '0;
      best_line_len_r <= '0;
      best_line_num_r <= 16'd1;
      wd_begin_r      <= '0;
      best_word_len_r <= '0;
      best_wd_begin_r <= '0;
      top_code_r      <= '0;
      top_total_r     <= '0;
      out_tvalid_r    <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_vld_r <= in_tvalid;
        s1_end_r <= in_tuser;
      end
      prev_r          <= prev_nxt;
      pos_r           <= pos_nxt;
      words_r         <= words_nxt;
      lines_r         <= lines_nxt;
      ln_begin_r      <= ln_begin_nxt;
      best_line_len_r <= best_line_len_nxt;
      best_line_num_r <= best_line_num_nxt;
      wd_begin_r      <= wd_begin_nxt;
      best_word_len_r <= best_word_len_nxt;
      best_wd_begin_r <= best_wd_begin_nxt;
      top_code_r      <= top_code_nxt;
      top_total_r     <= top_total_nxt;
      if (end_fire) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_char_r <= in_tdata;
    end
    if (end_fire) begin
      out_tdata_r <= {best_word_len_r, best_wd_begin_r, top_total_r, top_code_r,
                      best_line_len_r, best_line_num_r, lines_r, words_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_stall_only_end: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_vld_r && s1_end_r)
    else $error("input stalled without a pending end marker");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    end_fire |=> pos_r == '0 && top_total_r == '0 && out_tvalid)
    else $error("end marker did not clear state or raise a result");

  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    active |=> pos_r == $past(pos_r) + CNT_W'(1))
    else $error("position did not advance on a taken byte");

  a_top_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    byte_fire |=> top_total_r >= $past(top_total_r))
    else $error("top count decreased within a text");

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks text_statistics_engine against a predictor of its statistics
// ----------------------------------------------------------------------------
// Text bytes and end markers go in through the input stream. A scoreboard
// class mirrors the histogram, the word and line tracking and the top-byte
// logic, and it queues one predicted statistics record per end marker. Each
// record that leaves the block is compared field by field with the oldest
// prediction. A directed run covers the empty text, separator runs, NUL,
// comma, 0xFF, back-to-back end markers and open words or lines at the end.
// Random texts of mixed content follow, under three idle mixes.
// ----------------------------------------------------------------------------
module testbench
  import tse_pkg::*;
();

  // packed from msb down so that word_count lands in the low bits
  typedef struct packed {
    logic [15:0] longest_word_length;
    logic [15:0] longest_word_offset;
    logic [15:0] top_char_count;
    logic [7:0]  top_char;
    logic [15:0] longest_line_length;
    logic [15:0] longest_line_number;
    logic [15:0] line_count;
    logic [15:0] word_count;
  } text_stats_t;

  class text_stats_scoreboard;
    bit [15:0]   hist [256];
    bit [7:0]    prev_char;
    bit [7:0]    top_code;
    int          pos, words, lines, ln_begin, best_line_len, best_line_num;
    int          wd_begin, best_word_len, best_wd_begin, top_total;
    text_stats_t stats_q [$];
    int          errors;
    int          texts_done;
    int          results_checked;

    function new();
      errors = 0;
      texts_done = 0;
      results_checked = 0;
      clear();
    endfunction

    function void clear();
      foreach (hist[i]) hist[i] = '0;
      prev_char = CH_LF;
      top_code = '0;
      pos = 0;
      words = 0;
      lines = 0;
      ln_begin = 0;
      best_line_len = 0;
      best_line_num = 1;
      wd_begin = 0;
      best_word_len = 0;
      best_wd_begin = 0;
      top_total = 0;
    endfunction

    function bit breaks_word(bit [7:0] c);
      return c == CH_SPACE || c == CH_LF || c == CH_NUL || c == CH_COMMA;
    endfunction

    function int bump(int v);
      return (v < 65535) ? v + 1 : 65535;
    endfunction

    function bit [15:0] clip16(int v);
      return (v > 65535) ? 16'hFFFF : 16'(v);
    endfunction

    function void note_input(bit [7:0] c, bit last);
      text_stats_t s;
      int          n;
      int          len;
      bit          sep;
      bit          prev_sep;
      if (last) begin
        s.word_count          = clip16(words);
        s.line_count          = clip16(lines);
        s.longest_line_number = clip16(best_line_num);
        s.longest_line_length = clip16(best_line_len);
        s.top_char            = top_code;
        s.top_char_count      = clip16(top_total);
        s.longest_word_offset = clip16(best_wd_begin);
        s.longest_word_length = clip16(best_word_len);
        stats_q.push_back(s);
        texts_done++;
        clear();
        return;
      end
      if (pos >= int'(MAX_CHARS)) return;
      sep = breaks_word(c);
      prev_sep = breaks_word(prev_char);

      n = bump(int'(hist[c]));
      hist[c] = 16'(n);
      if (n > top_total || (n == top_total && c < top_code)) begin
        top_total = n;
        top_code = c;
      end

      if (prev_sep && !sep) begin
        words = bump(words);
        wd_begin = pos;
      end else if (sep && !prev_sep) begin
        len = pos - wd_begin;
        if (len > best_word_len) begin
          best_word_len = len;
          best_wd_begin = wd_begin;
        end
      end

      if (prev_char == CH_LF) begin
        lines = bump(lines);
        ln_begin = pos;
      end
      if (c == CH_LF) begin
        len = pos - ln_begin + 1;
        if (len > best_line_len) begin
          best_line_len = len;
          best_line_num = lines;
        end
      end

      prev_char = c;
      pos++;
    endfunction

    task report(string msg);
      $display("%0t ns  error: %s", $time, msg);
      errors++;
    endtask

    task same_field(string name, int got, int want);
      if (got != want) report($sformatf("%s got %0d, want %0d", name, got, want));
    endtask

    task check_result(text_stats_t got);
      text_stats_t want;
      if (stats_q.size() == 0) begin
        report($sformatf("statistics result with none pending: %h", got));
        return;
      end
      want = stats_q.pop_front();
      results_checked++;
      same_field("word_count", got.word_count, want.word_count);
      same_field("line_count", got.line_count, want.line_count);
      same_field("longest_line_number", got.longest_line_number,
                 want.longest_line_number);
      same_field("longest_line_length", got.longest_line_length,
                 want.longest_line_length);
      same_field("top_char", got.top_char, want.top_char);
      same_field("top_char_count", got.top_char_count, want.top_char_count);
      same_field("longest_word_offset", got.longest_word_offset,
                 want.longest_word_offset);
      same_field("longest_word_length", got.longest_word_length,
                 want.longest_word_length);
    endtask
  endclass

  logic         clk;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata   = '0;
  logic         in_tuser   = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [119:0] out_tdata;

  int in_idle_pct  = 7;
  int out_idle_pct = 55;
  int items_sent   = 0;
  int goal;

  text_stats_scoreboard sb = new();

  text_statistics_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(text_stats_t'(out_tdata));
  end

  task automatic send_item(input bit [7:0] c, input bit last);
    while ($urandom_range(99) < in_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tuser  <= last;
    do @(posedge clk); while (!in_tready);
    sb.note_input(c, last);
    items_sent++;
  endtask

  task automatic send_str(input string s);
    foreach (s[i]) send_item(s[i], 1'b0);
  endtask

  // small alphabet so that top-byte ties and repeated words are common
  function automatic bit [7:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 45) return 8'(8'h61 + $urandom_range(4));
    if (r < 60) return 8'(8'h61 + $urandom_range(25));
    if (r < 72) return CH_SPACE;
    if (r < 80) return CH_LF;
    if (r < 84) return CH_COMMA;
    if (r < 87) return CH_NUL;
    return 8'($urandom_range(255));
  endfunction

  task automatic send_random_text();
    int kind;
    int len;
    bit noise;
    kind  = $urandom_range(99);
    len   = (kind < 8) ? 0 : (kind < 90) ? $urandom_range(24, 1) : $urandom_range(60, 25);
    noise = ($urandom_range(9) == 0);
    repeat (len) send_item(noise ? 8'($urandom_range(255)) : pick_char(), 1'b0);
    send_item(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.stats_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed texts
    send_item(CH_NUL, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(CH_NUL, 1'b0);
    send_str("ab");
    send_item(CH_COMMA, 1'b0);
    send_str("bb\n x");
    send_item(8'h5A, 1'b1);
    send_str("\nab ab\n");
    send_item(CH_NUL, 1'b1);
    send_item(CH_SPACE, 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(CH_NUL, 1'b1);
    send_item(8'hFF, 1'b1);

    // hold the sender until every pending result is back
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      in_idle_pct  = (phase == 0) ? 7 : (phase == 1) ? 55 : 0;
      out_idle_pct = (phase == 0) ? 55 : (phase == 1) ? 7 : 0;
      goal = items_sent + 385;
      while (items_sent < goal) send_random_text();
      wait_drained();
    end

    wait_drained();
    repeat (10) @(posedge clk);

    $display("sent %0d requests forming %0d texts", items_sent, sb.texts_done);
    $display("checked %0d statistics results under three idle mixes",
             sb.results_checked);
    if (sb.stats_q.size() != 0)
      sb.report($sformatf("%0d statistics results never arrived", sb.stats_q.size()));
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/tse_pkg.sv
sv/tse_hist.sv
sv/text_statistics_engine.sv
dv/testbench.sv
